[hw/rtl/cis_pkg.sv]
// ----------------------------------------------------------------------------
// cis_pkg
// Shared types, constants and helpers of the case-insensitive substring search.
// ----------------------------------------------------------------------------
package cis_pkg;

    localparam int MAX_NEEDLE_DEF    = 32;
    localparam int POSITION_BITS_DEF = 16;

    localparam int CODE_W  = 21;
    localparam int IDX_W   = 5;
    localparam int LEN_W   = 6;
    localparam int COUNT_W = 20;
    localparam int OP_W    = 2;

    localparam logic [CODE_W-1:0] SKIP_MARK   = 21'h000001;
    localparam logic [CODE_W-1:0] UPPER_FIRST = 21'h000041;
    localparam logic [CODE_W-1:0] UPPER_LAST  = 21'h00005A;
    localparam logic [CODE_W-1:0] LOWER_FIRST = 21'h000061;

    typedef enum logic [OP_W-1:0] {
        OP_NEW_SEARCH = 2'd0,
        OP_LOAD       = 2'd1,
        OP_TEXT       = 2'd2,
        OP_EMPTY_LINE = 2'd3
    } op_t;

    typedef struct packed {
        logic              clear;
        logic              shift;
        logic              fresh;
        logic [CODE_W-1:0] code;
    } cell_ctl_t;

    function automatic logic [CODE_W-1:0] fold_case(input logic [CODE_W-1:0] c);
        logic [CODE_W-1:0] r;
        r = c;
        if (c >= UPPER_FIRST && c <= UPPER_LAST) begin
            r = c - UPPER_FIRST + LOWER_FIRST;
        end
        return r;
    endfunction

endpackage

[hw/rtl/cis_cell.sv]
// ----------------------------------------------------------------------------
// cis_cell
// One needle position: holds its character and the prefix bit, and hands the
// prefix bit to the next position on every text character that is not skipped.
// ----------------------------------------------------------------------------
module cis_cell #(
    parameter bit HEAD = 1'b0
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  cis_pkg::cell_ctl_t        ctl,
    input  logic                      load_sel,
    input  logic                      carry_in,
    output logic                      carry_out,
    output logic                      bit_next
);

    logic [cis_pkg::CODE_W-1:0] needle_reg;
    logic                       bit_reg;
    logic                       carry_eff;

    always_comb begin
        carry_eff = HEAD ? 1'b1 : (carry_in & ~ctl.fresh);
        bit_next  = carry_eff & (needle_reg == ctl.code);
    end

    assign carry_out = bit_reg;

    always_ff @(posedge aclk) begin
        if (load_sel) begin
            needle_reg <= ctl.code;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= 1'b0;
        end else if (ctl.clear) begin
            bit_reg <= 1'b0;
        end else if (ctl.shift) begin
            bit_reg <= bit_next;
        end
    end

endmodule

[hw/rtl/case_insensitive_substring_search_top.sv]
// ----------------------------------------------------------------------------
// case_insensitive_substring_search_top
// Streaming case-insensitive substring search over a row of needle cells.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata                          | tuser
//  s_axis   | in        | char_code, needle_index        | operation, first_of_line
//  m_axis   | out       | match_row, match_col, count    | -
//  cfg      | in        | needle_length (write only)     | -
//
//  One request per cycle while s_axis_tready is high; its match, if any, appears on m_axis the next cycle.
//  All needle cells compare against the character in the same cycle.
//  A waiting match holds the output register; s_axis_tready stays high while
//  the output register is empty or being taken.
//  Synchronous active-low reset; needle characters are not reset.
// ----------------------------------------------------------------------------
module case_insensitive_substring_search_top #(
    parameter int MAX_NEEDLE    = cis_pkg::MAX_NEEDLE_DEF,
    parameter int POSITION_BITS = cis_pkg::POSITION_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [cis_pkg::LEN_W-1:0]         cfg_wr_data,   // needle_length
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [31:0]                       s_axis_tdata,  // char_code, needle_index
    input  logic [2:0]                        s_axis_tuser,  // operation, first_of_line
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // match_row, match_col, match_count
    output logic [((2*POSITION_BITS+cis_pkg::COUNT_W+7)/8)*8-1:0] m_axis_tdata
);

    localparam int NW     = (MAX_NEEDLE > 1) ? $clog2(MAX_NEEDLE) : 1;
    localparam int PB     = POSITION_BITS;
    localparam int CW     = POSITION_BITS + 1;
    localparam int OUT_W  = ((2*POSITION_BITS+cis_pkg::COUNT_W+7)/8)*8;
    localparam int PAD_W  = OUT_W - 2*POSITION_BITS - cis_pkg::COUNT_W;
    localparam logic [CW-1:0] COL_CAP =
        CW'((64'(1) << POSITION_BITS) - 64'(1) + 64'(MAX_NEEDLE));

    logic [cis_pkg::CODE_W-1:0] in_code;
    logic [cis_pkg::IDX_W-1:0]  in_idx;
    cis_pkg::op_t               in_op;
    logic                       in_first;
    logic                       accept;

    logic [PB-1:0]                 line_reg, line_next;
    logic                          begun_reg, begun_next;
    logic [CW-1:0]                 col_reg, col_next;
    logic                          skip_reg, skip_next;
    logic [cis_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [cis_pkg::LEN_W-1:0]     len_reg, len_next;
    logic                          out_valid_reg, out_valid_next;
    logic [PB-1:0]                 out_row_reg, out_row_next;
    logic [PB-1:0]                 out_col_reg, out_col_next;
    logic [cis_pkg::COUNT_W-1:0]   out_count_reg, out_count_next;

    cis_pkg::cell_ctl_t            ctl;
    logic [MAX_NEEDLE-1:0]         load_sel;
    logic [MAX_NEEDLE-1:0]         bits;
    logic [MAX_NEEDLE-1:0]         bits_next;

    logic                          is_text;
    logic                          begin_txt;
    logic                          begin_any;
    logic                          skip_now;
    logic                          hit;
    logic [cis_pkg::LEN_W-1:0]     len_eff;
    logic [cis_pkg::LEN_W-1:0]     len_m1;
    logic [NW-1:0]                 hit_sel;
    logic [CW-1:0]                 col_cur;
    logic [CW-1:0]                 start;
    logic [PB-1:0]                 start_sat;

    assign in_code  = s_axis_tdata[cis_pkg::CODE_W-1:0];
    assign in_idx   = s_axis_tdata[cis_pkg::CODE_W +: cis_pkg::IDX_W];
    assign in_op    = cis_pkg::op_t'(s_axis_tuser[cis_pkg::OP_W-1:0]);
    assign in_first = s_axis_tuser[cis_pkg::OP_W];

    assign s_axis_tready = ~out_valid_reg | m_axis_tready;
    assign accept        = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_count_reg, out_col_reg, out_row_reg};

    genvar k;
    generate
        for (k = 0; k < MAX_NEEDLE; k++) begin : g_cell
            assign load_sel[k] = accept && (in_op == cis_pkg::OP_LOAD) &&
                                 (32'(in_idx) == k);
            if (k == 0) begin : g_head
                cis_cell #(.HEAD(1'b1)) u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .ctl      (ctl),
                    .load_sel (load_sel[k]),
                    .carry_in (1'b1),
                    .carry_out(bits[k]),
                    .bit_next (bits_next[k])
                );
            end else begin : g_body
                cis_cell #(.HEAD(1'b0)) u_cell (
                    .aclk     (aclk),
                    .aresetn  (aresetn),
                    .ctl      (ctl),
                    .load_sel (load_sel[k]),
                    .carry_in (bits[k-1]),
                    .carry_out(bits[k]),
                    .bit_next (bits_next[k])
                );
            end
        end
    endgenerate

    always_comb begin
        is_text   = accept && (in_op == cis_pkg::OP_TEXT);
        begin_txt = is_text && (in_first || !begun_reg);
        begin_any = begin_txt || (accept && (in_op == cis_pkg::OP_EMPTY_LINE));
        skip_now  = begin_txt ? (in_code == cis_pkg::SKIP_MARK) : skip_reg;

        ctl.code  = cis_pkg::fold_case(in_code);
        ctl.fresh = begin_txt;
        ctl.shift = is_text && !skip_now;
        ctl.clear = (accept && (in_op == cis_pkg::OP_NEW_SEARCH ||
                                in_op == cis_pkg::OP_LOAD ||
                                in_op == cis_pkg::OP_EMPTY_LINE)) ||
                    (begin_txt && skip_now);

        if (32'(len_reg) > MAX_NEEDLE) begin
            len_eff = cis_pkg::LEN_W'(MAX_NEEDLE);
        end else begin
            len_eff = len_reg;
        end
        len_m1  = len_eff - cis_pkg::LEN_W'(1);
        hit_sel = NW'(len_m1);
        hit     = ctl.shift && (len_eff != '0) && bits_next[hit_sel];

        col_cur = begin_txt ? '0 : col_reg;
        if (col_cur >= CW'(len_m1)) begin
            start = col_cur - CW'(len_m1);
        end else begin
            start = '0;
        end
        start_sat = start[CW-1] ? {PB{1'b1}} : start[PB-1:0];

        line_next      = line_reg;
        begun_next     = begun_reg;
        col_next       = col_reg;
        skip_next      = skip_reg;
        count_next     = count_reg;
        len_next       = cfg_wr_en ? cfg_wr_data : len_reg;
        out_valid_next = out_valid_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        out_count_next = out_count_reg;

        if (accept && in_op == cis_pkg::OP_NEW_SEARCH) begin
            line_next  = '1;
            begun_next = 1'b0;
            col_next   = '0;
            skip_next  = 1'b0;
            count_next = '0;
        end

        if (begin_any) begin
            if (!begun_reg) begin
                line_next = '0;
            end else if (!(&line_reg)) begin
                line_next = line_reg + PB'(1);
            end
            begun_next = 1'b1;
            col_next   = '0;
            skip_next  = begin_txt ? skip_now : 1'b0;
        end

        if (ctl.shift) begin
            col_next = (col_cur < COL_CAP) ? col_cur + CW'(1) : col_cur;
        end

        if (hit && !(&count_reg)) begin
            count_next = count_reg + cis_pkg::COUNT_W'(1);
        end

        if (accept) begin
            out_valid_next = hit;
            if (hit) begin
                out_row_next   = line_reg;
                out_col_next   = start_sat;
                out_count_next = (&count_reg) ? count_reg
                                              : count_reg + cis_pkg::COUNT_W'(1);
            end
            if (begin_any && hit) begin
                out_row_next = line_next;
            end
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_reg      <= '1;
            begun_reg     <= 1'b0;
            col_reg       <= '0;
            skip_reg      <= 1'b0;
            count_reg     <= '0;
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            line_reg      <= line_next;
            begun_reg     <= begun_next;
            col_reg       <= col_next;
            skip_reg      <= skip_next;
            count_reg     <= count_next;
            len_reg       <= len_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_row_reg   <= out_row_next;
        out_col_reg   <= out_col_next;
        out_count_reg <= out_count_next;
    end

endmodule
